// ----- sv/clpu_pkg.sv -----
// ----------------------------------------------------------------------------
// clpu_pkg
// Shared sizes, codes and types of the cursor linked list pool unit.
// ----------------------------------------------------------------------------
package clpu_pkg;

	localparam int NUM_NODES = 64;
	localparam int NUM_LISTS = 4;
	localparam int ITEM_BITS = 32;

	localparam int NODE_W  = $clog2(NUM_NODES);
	localparam int LIST_W  = $clog2(NUM_LISTS);
	localparam int CNT_W   = $clog2(NUM_NODES + 1);
	localparam int LCNT_W  = $clog2(NUM_LISTS + 1);
	localparam int KIND_W  = 4;
	localparam int STAT_W  = 2;

	typedef logic [NODE_W-1:0]    node_t;
	typedef logic [LIST_W-1:0]    list_t;
	typedef logic [CNT_W-1:0]     cnt_t;
	typedef logic [ITEM_BITS-1:0] item_t;

	typedef enum logic [KIND_W-1:0] {
		K_CREATE  = 4'd0,
		K_COUNT   = 4'd1,
		K_FIRST   = 4'd2,
		K_LAST    = 4'd3,
		K_NEXT    = 4'd4,
		K_PREV    = 4'd5,
		K_CURR    = 4'd6,
		K_ADD     = 4'd7,
		K_INSERT  = 4'd8,
		K_APPEND  = 4'd9,
		K_PREPEND = 4'd10,
		K_REMOVE  = 4'd11,
		K_CONCAT  = 4'd12,
		K_FREE    = 4'd13,
		K_TRIM    = 4'd14,
		K_SEARCH  = 4'd15
	} kind_t;

	localparam logic [STAT_W-1:0] ST_OK       = 2'd0;
	localparam logic [STAT_W-1:0] ST_EXHAUST  = 2'd1;
	localparam logic [STAT_W-1:0] ST_NOHANDLE = 2'd2;

	// Write ports of the node memory
	typedef struct packed {
		logic  item_we;
		node_t item_wa;
		item_t item_wd;
		logic  next_we;
		node_t next_wa;
		node_t next_wd;
		logic  prev_we;
		node_t prev_wa;
		node_t prev_wd;
	} node_wr_t;

endpackage

// ----- sv/clpu_if.sv -----
// ----------------------------------------------------------------------------
// clpu_if
// Command, response and configuration channels of the list pool unit.
// ----------------------------------------------------------------------------
interface clpu_cmd_if
	import clpu_pkg::*;
();
	logic                valid;
	logic                ready;
	logic [KIND_W-1:0]   kind;
	logic [LIST_W-1:0]   list_id;
	logic [LIST_W-1:0]   second_list_id;
	logic [ITEM_BITS-1:0] item_value;

	modport source (output valid, kind, list_id, second_list_id, item_value, input ready);
	modport sink (input valid, kind, list_id, second_list_id, item_value, output ready);
endinterface

interface clpu_rsp_if
	import clpu_pkg::*;
();
	logic                 valid;
	logic                 ready;
	logic [STAT_W-1:0]    status;
	logic [ITEM_BITS-1:0] item_out;
	logic                 item_valid;
	logic [CNT_W-1:0]     list_count;
	logic [LIST_W-1:0]    new_list_id;
	logic                 last;

	modport source (output valid, status, item_out, item_valid, list_count, new_list_id, last,
		input ready);
	modport sink (input valid, status, item_out, item_valid, list_count, new_list_id, last,
		output ready);
endinterface

interface clpu_cfg_if
	import clpu_pkg::*;
();
	logic                 valid;
	logic                 ready;
	logic [ITEM_BITS-1:0] data;

	modport source (output valid, data, input ready);
	modport sink (input valid, data, output ready);
endinterface

// ----- sv/cursor_linked_list_pool_unit.sv -----
// ----------------------------------------------------------------------------
// cursor_linked_list_pool_unit
// Cursor based doubly linked lists sharing one node pool and a handle pool.
// ----------------------------------------------------------------------------
// Usage:
//  cmd  : one command item per handshake (kind, list_id, second_list_id,
//         item_value). Accepted only while the sequencer is idle.
//  rsp  : one response item per command; free sends one per list node,
//         head first, with last set on the final one.
//  cfg  : write of match_mask, taken any cycle; write it only while idle.
// Sequence: a command passes through decode, then the node memory
//  read/modify/write steps, then into the response register. Search
//  walks one node per cycle from the cursor; free visits each node in a
//  free step, with an emit and a read step between nodes. The single read
//  port of the node memory sets this order.
// Reset: all lists unallocated, node and handle pools fresh, mask all ones.
//  The node memory is not cleared; it is read only where it was written.
// Stall: the response register holds an item until rsp.ready; the sequencer
//  waits in its emit step, so a free walk pauses node by node.
// ----------------------------------------------------------------------------
module cursor_linked_list_pool_unit
	import clpu_pkg::*;
(
	input logic          clk,
	input logic          arst_n,
	clpu_cmd_if.sink     cmd,
	clpu_rsp_if.source   rsp,
	clpu_cfg_if.sink     cfg
);

	typedef enum logic [3:0] {
		S_IDLE, S_DEC, S_ITEM, S_NX, S_PV, S_ADD1, S_ADD2, S_ADD3,
		S_RM, S_TR, S_GIVE, S_FREE_RD, S_FREE, S_SR, S_EMIT
	} state_t;

	typedef enum logic [1:0] {M_BACK, M_FRONT, M_AFTER, M_BEFORE} mode_t;

	state_t st_q;
	mode_t  mode_q;

	// list table
	node_t head_q [NUM_LISTS];
	node_t tail_q [NUM_LISTS];
	node_t cur_q [NUM_LISTS];
	logic [NUM_LISTS-1:0] cur_v_q;
	cnt_t  items_q [NUM_LISTS];
	logic [NUM_LISTS-1:0] bey_q;
	logic [NUM_LISTS-1:0] inuse_q;

	// pools
	node_t fntop_q;
	cnt_t  fntot_q;
	cnt_t  fresh_n_q;
	list_t flink_q [NUM_LISTS];
	list_t fltop_q;
	logic [LCNT_W-1:0] fltot_q;
	logic [LCNT_W-1:0] fresh_l_q;

	item_t mask_q;

	// command and snapshot of its list
	kind_t kind_q;
	list_t l_q, l2_q;
	item_t v_q;
	node_t hd_q, tl_q, c_q;
	logic  cv_q, bey_s_q;
	cnt_t  cnt_q;

	node_t n_q, a_q;
	cnt_t  it_q;
	logic  pop_q;

	// pending result
	logic [STAT_W-1:0] res_status_q;
	item_t             res_item_q;
	logic              res_iv_q;
	cnt_t              res_cnt_q;
	list_t             res_nid_q;
	logic              res_last_q;

	// response register
	logic              out_v_q;
	logic [STAT_W-1:0] out_status_q;
	item_t             out_item_q;
	logic              out_iv_q;
	cnt_t              out_cnt_q;
	list_t             out_nid_q;
	logic              out_last_q;

	node_t    rd_addr;
	node_wr_t wr;
	item_t    item_rd;
	node_t    next_rd, prev_rd;

	logic  err_w, cat_link_w, match_w, emit_w;
	list_t h_w;
	node_t hd2_w, tl2_w;
	cnt_t  cnt2_w;

	clpu_node_mem u_mem (
		.clk     (clk),
		.rd_addr (rd_addr),
		.wr      (wr),
		.item_rd (item_rd),
		.next_rd (next_rd),
		.prev_rd (prev_rd)
	);

	assign cmd.ready = (st_q == S_IDLE);
	assign cfg.ready = 1'b1;

	assign rsp.valid      = out_v_q;
	assign rsp.status     = out_status_q;
	assign rsp.item_out   = out_item_q;
	assign rsp.item_valid = out_iv_q;
	assign rsp.list_count = out_cnt_q;
	assign rsp.new_list_id = out_nid_q;
	assign rsp.last       = out_last_q;

	assign emit_w     = (st_q == S_EMIT) && (!out_v_q || rsp.ready);
	assign err_w      = !inuse_q[l_q] || (kind_q == K_CONCAT && !inuse_q[l2_q]);
	assign hd2_w      = head_q[l2_q];
	assign tl2_w      = tail_q[l2_q];
	assign cnt2_w     = items_q[l2_q];
	assign cat_link_w = (kind_q == K_CONCAT) && !err_w && (l2_q != l_q) &&
		(cnt_q != '0) && (cnt2_w != '0);
	assign match_w    = ((item_rd & mask_q) == (v_q & mask_q));
	assign h_w        = (fresh_l_q < LCNT_W'(NUM_LISTS)) ? fresh_l_q[LIST_W-1:0] : fltop_q;

	// read address: present the node the next step needs
	always_comb begin
		rd_addr = n_q;
		unique case (st_q)
			S_DEC: begin
				case (kind_q)
					K_FIRST, K_FREE:  rd_addr = hd_q;
					K_LAST, K_TRIM:   rd_addr = tl_q;
					K_NEXT:           rd_addr = cv_q ? c_q : hd_q;
					K_PREV:           rd_addr = cv_q ? c_q : tl_q;
					K_ADD, K_INSERT, K_APPEND, K_PREPEND: rd_addr = fntop_q;
					default:          rd_addr = c_q;
				endcase
			end
			S_ADD1:           rd_addr = c_q;
			S_NX, S_SR:       rd_addr = next_rd;
			S_PV:             rd_addr = prev_rd;
			default:          rd_addr = n_q;
		endcase
	end

	// item and link writes
	always_comb begin
		wr = '0;
		unique case (st_q)
			S_DEC: begin
				if (cat_link_w) begin
					wr.next_we = 1'b1; wr.next_wa = tl_q;  wr.next_wd = hd2_w;
					wr.prev_we = 1'b1; wr.prev_wa = hd2_w; wr.prev_wd = tl_q;
				end
			end
			S_ADD1: begin
				wr.item_we = 1'b1; wr.item_wa = n_q; wr.item_wd = v_q;
			end
			S_ADD2: begin
				unique case (mode_q)
					M_BACK: begin
						if (cnt_q != '0) begin
							wr.prev_we = 1'b1; wr.prev_wa = n_q;  wr.prev_wd = tl_q;
							wr.next_we = 1'b1; wr.next_wa = tl_q; wr.next_wd = n_q;
						end
					end
					M_FRONT: begin
						if (cnt_q != '0) begin
							wr.next_we = 1'b1; wr.next_wa = n_q;  wr.next_wd = hd_q;
							wr.prev_we = 1'b1; wr.prev_wa = hd_q; wr.prev_wd = n_q;
						end
					end
					M_AFTER: begin
						wr.next_we = 1'b1; wr.next_wa = n_q; wr.next_wd = next_rd;
						wr.prev_we = 1'b1; wr.prev_wa = n_q; wr.prev_wd = c_q;
					end
					M_BEFORE: begin
						wr.next_we = 1'b1; wr.next_wa = n_q; wr.next_wd = c_q;
						wr.prev_we = 1'b1; wr.prev_wa = n_q; wr.prev_wd = prev_rd;
					end
					default: wr = '0;
				endcase
			end
			S_ADD3: begin
				if (mode_q == M_AFTER) begin
					wr.prev_we = 1'b1; wr.prev_wa = a_q; wr.prev_wd = n_q;
					wr.next_we = 1'b1; wr.next_wa = c_q; wr.next_wd = n_q;
				end else begin
					wr.next_we = 1'b1; wr.next_wa = a_q; wr.next_wd = n_q;
					wr.prev_we = 1'b1; wr.prev_wa = c_q; wr.prev_wd = n_q;
				end
			end
			S_RM: begin
				// unlink a node in the middle
				if (cnt_q != cnt_t'(1) && c_q != hd_q && c_q != tl_q) begin
					wr.next_we = 1'b1; wr.next_wa = prev_rd; wr.next_wd = next_rd;
					wr.prev_we = 1'b1; wr.prev_wa = next_rd; wr.prev_wd = prev_rd;
				end
			end
			S_GIVE, S_FREE: begin
				// push the node on the free stack
				wr.next_we = 1'b1; wr.next_wa = n_q; wr.next_wd = fntop_q;
			end
			default: wr = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q      <= S_IDLE;
			mode_q    <= M_BACK;
			cur_v_q   <= '0;
			bey_q     <= '0;
			inuse_q   <= '0;
			for (int i = 0; i < NUM_LISTS; i++) begin
				head_q[i]  <= '0;
				tail_q[i]  <= '0;
				cur_q[i]   <= '0;
				items_q[i] <= '0;
				flink_q[i] <= '0;
			end
			fntop_q   <= '0;
			fntot_q   <= '0;
			fresh_n_q <= '0;
			fltop_q   <= '0;
			fltot_q   <= '0;
			fresh_l_q <= '0;
			mask_q    <= '1;
			kind_q    <= K_CREATE;
			l_q       <= '0;
			l2_q      <= '0;
			v_q       <= '0;
			hd_q      <= '0;
			tl_q      <= '0;
			c_q       <= '0;
			cv_q      <= 1'b0;
			bey_s_q   <= 1'b0;
			cnt_q     <= '0;
			n_q       <= '0;
			a_q       <= '0;
			it_q      <= '0;
			pop_q     <= 1'b0;
			res_status_q <= ST_OK;
			res_item_q   <= '0;
			res_iv_q     <= 1'b0;
			res_cnt_q    <= '0;
			res_nid_q    <= '0;
			res_last_q   <= 1'b1;
			out_v_q      <= 1'b0;
			out_status_q <= ST_OK;
			out_item_q   <= '0;
			out_iv_q     <= 1'b0;
			out_cnt_q    <= '0;
			out_nid_q    <= '0;
			out_last_q   <= 1'b0;
		end else begin
			if (cfg.valid) begin
				mask_q <= cfg.data;
			end

			// response register: load on emit, drop when taken
			if (emit_w) begin
				out_v_q      <= 1'b1;
				out_status_q <= res_status_q;
				out_item_q   <= res_item_q;
				out_iv_q     <= res_iv_q;
				out_cnt_q    <= res_cnt_q;
				out_nid_q    <= res_nid_q;
				out_last_q   <= res_last_q;
			end else if (rsp.ready) begin
				out_v_q <= 1'b0;
			end

			unique case (st_q)
				S_IDLE: begin
					if (cmd.valid) begin
						kind_q  <= kind_t'(cmd.kind);
						l_q     <= cmd.list_id;
						l2_q    <= cmd.second_list_id;
						v_q     <= cmd.item_value;
						hd_q    <= head_q[cmd.list_id];
						tl_q    <= tail_q[cmd.list_id];
						c_q     <= cur_q[cmd.list_id];
						cv_q    <= cur_v_q[cmd.list_id];
						bey_s_q <= bey_q[cmd.list_id];
						cnt_q   <= items_q[cmd.list_id];
						st_q    <= S_DEC;
					end
				end

				S_DEC: begin
					// default result: ok, null item, current count
					res_status_q <= ST_OK;
					res_item_q   <= '0;
					res_iv_q     <= 1'b0;
					res_cnt_q    <= cnt_q;
					res_nid_q    <= '0;
					res_last_q   <= 1'b1;
					st_q         <= S_EMIT;
					if (kind_q == K_CREATE) begin
						res_cnt_q <= '0;
						if (fresh_l_q < LCNT_W'(NUM_LISTS) || fltot_q != '0) begin
							if (fresh_l_q < LCNT_W'(NUM_LISTS)) begin
								fresh_l_q <= fresh_l_q + 1'b1;
							end else begin
								fltop_q <= flink_q[fltop_q];
								fltot_q <= fltot_q - 1'b1;
							end
							inuse_q[h_w] <= 1'b1;
							items_q[h_w] <= '0;
							cur_v_q[h_w] <= 1'b0;
							cur_q[h_w]   <= '0;
							bey_q[h_w]   <= 1'b0;
							res_nid_q    <= h_w;
						end else begin
							res_status_q <= ST_EXHAUST;
						end
					end else if (err_w) begin
						res_status_q <= ST_NOHANDLE;
						res_cnt_q    <= '0;
					end else begin
						case (kind_q)
							K_FIRST, K_LAST: begin
								if (cnt_q != '0) begin
									cur_q[l_q]   <= (kind_q == K_FIRST) ? hd_q : tl_q;
									cur_v_q[l_q] <= 1'b1;
									st_q         <= S_ITEM;
								end
							end
							K_NEXT: begin
								if (cnt_q != '0) begin
									if (cv_q && c_q == tl_q) begin
										cur_v_q[l_q] <= 1'b0;
										bey_q[l_q]   <= 1'b1;
									end else if (!cv_q) begin
										if (!bey_s_q) begin
											cur_q[l_q]   <= hd_q;
											cur_v_q[l_q] <= 1'b1;
											st_q         <= S_ITEM;
										end
									end else begin
										st_q <= S_NX;
									end
								end
							end
							K_PREV: begin
								if (cnt_q != '0) begin
									if (cv_q && c_q == hd_q) begin
										cur_v_q[l_q] <= 1'b0;
										bey_q[l_q]   <= 1'b0;
									end else if (!cv_q) begin
										if (bey_s_q) begin
											cur_q[l_q]   <= tl_q;
											cur_v_q[l_q] <= 1'b1;
											st_q         <= S_ITEM;
										end
									end else begin
										st_q <= S_PV;
									end
								end
							end
							K_CURR: begin
								if (cv_q) begin
									st_q <= S_ITEM;
								end
							end
							K_ADD, K_INSERT, K_APPEND, K_PREPEND: begin
								// take a node: fresh first, then the free stack
								if (fresh_n_q < CNT_W'(NUM_NODES)) begin
									n_q       <= fresh_n_q[NODE_W-1:0];
									fresh_n_q <= fresh_n_q + 1'b1;
									pop_q     <= 1'b0;
									st_q      <= S_ADD1;
								end else if (fntot_q != '0) begin
									n_q     <= fntop_q;
									fntot_q <= fntot_q - 1'b1;
									pop_q   <= 1'b1;
									st_q    <= S_ADD1;
								end else begin
									res_status_q <= ST_EXHAUST;
								end
								// null links repaired: tail add appends, head insert prepends
								if (kind_q == K_APPEND) begin
									mode_q <= M_BACK;
								end else if (kind_q == K_PREPEND) begin
									mode_q <= M_FRONT;
								end else if (cnt_q == '0) begin
									mode_q <= M_BACK;
								end else if (!cv_q) begin
									mode_q <= bey_s_q ? M_BACK : M_FRONT;
								end else if (kind_q == K_ADD && c_q == tl_q) begin
									mode_q <= M_BACK;
								end else if (kind_q == K_INSERT && c_q == hd_q) begin
									mode_q <= M_FRONT;
								end else if (kind_q == K_ADD) begin
									mode_q <= M_AFTER;
								end else begin
									mode_q <= M_BEFORE;
								end
							end
							K_REMOVE: begin
								if (cnt_q != '0 && cv_q) begin
									st_q <= S_RM;
								end
							end
							K_TRIM: begin
								if (cnt_q != '0) begin
									n_q  <= tl_q;
									st_q <= S_TR;
								end
							end
							K_CONCAT: begin
								if (l2_q != l_q) begin
									if (cnt_q == '0) begin
										head_q[l_q]  <= hd2_w;
										tail_q[l_q]  <= tl2_w;
										items_q[l_q] <= cnt2_w;
										bey_q[l_q]   <= 1'b0;
										res_cnt_q    <= cnt2_w;
									end else if (cnt2_w != '0) begin
										tail_q[l_q]  <= tl2_w;
										items_q[l_q] <= cnt_q + cnt2_w;
										res_cnt_q    <= cnt_q + cnt2_w;
									end
									// release the second handle
									items_q[l2_q] <= '0;
									cur_v_q[l2_q] <= 1'b0;
									inuse_q[l2_q] <= 1'b0;
									flink_q[l2_q] <= fltop_q;
									fltop_q       <= l2_q;
									fltot_q       <= fltot_q + 1'b1;
								end
							end
							K_FREE: begin
								res_cnt_q <= '0;
								if (cnt_q == '0) begin
									items_q[l_q] <= '0;
									cur_v_q[l_q] <= 1'b0;
									inuse_q[l_q] <= 1'b0;
									flink_q[l_q] <= fltop_q;
									fltop_q      <= l_q;
									fltot_q      <= fltot_q + 1'b1;
								end else begin
									it_q <= cnt_q;
									n_q  <= hd_q;
									st_q <= S_FREE;
								end
							end
							K_SEARCH: begin
								if (!cv_q) begin
									cur_v_q[l_q] <= 1'b0;
									bey_q[l_q]   <= 1'b1;
								end else begin
									n_q  <= c_q;
									it_q <= '0;
									st_q <= S_SR;
								end
							end
							default: begin
							end
						endcase
					end
				end

				S_ITEM: begin
					res_item_q <= item_rd;
					res_iv_q   <= 1'b1;
					st_q       <= S_EMIT;
				end

				S_NX: begin
					cur_q[l_q]   <= next_rd;
					cur_v_q[l_q] <= 1'b1;
					st_q         <= S_ITEM;
				end

				S_PV: begin
					cur_q[l_q]   <= prev_rd;
					cur_v_q[l_q] <= 1'b1;
					st_q         <= S_ITEM;
				end

				S_ADD1: begin
					if (pop_q) begin
						fntop_q <= next_rd;
					end
					st_q <= S_ADD2;
				end

				S_ADD2: begin
					cur_q[l_q]   <= n_q;
					cur_v_q[l_q] <= 1'b1;
					items_q[l_q] <= cnt_q + 1'b1;
					res_cnt_q    <= cnt_q + 1'b1;
					unique case (mode_q)
						M_BACK: begin
							if (cnt_q == '0) begin
								head_q[l_q] <= n_q;
							end
							tail_q[l_q] <= n_q;
							st_q        <= S_EMIT;
						end
						M_FRONT: begin
							if (cnt_q == '0) begin
								tail_q[l_q] <= n_q;
							end
							head_q[l_q] <= n_q;
							st_q        <= S_EMIT;
						end
						M_AFTER: begin
							a_q  <= next_rd;
							st_q <= S_ADD3;
						end
						M_BEFORE: begin
							a_q  <= prev_rd;
							st_q <= S_ADD3;
						end
						default: st_q <= S_EMIT;
					endcase
				end

				S_ADD3: begin
					st_q <= S_EMIT;
				end

				S_RM: begin
					res_item_q   <= item_rd;
					res_iv_q     <= 1'b1;
					res_cnt_q    <= cnt_q - 1'b1;
					items_q[l_q] <= cnt_q - 1'b1;
					if (cnt_q == cnt_t'(1)) begin
						cur_v_q[l_q] <= 1'b0;
					end else if (c_q == hd_q) begin
						head_q[l_q] <= next_rd;
						cur_q[l_q]  <= next_rd;
					end else if (c_q == tl_q) begin
						tail_q[l_q] <= prev_rd;
						cur_q[l_q]  <= prev_rd;
					end else begin
						cur_q[l_q] <= next_rd;
					end
					n_q  <= c_q;
					st_q <= S_GIVE;
				end

				S_TR: begin
					res_item_q   <= item_rd;
					res_iv_q     <= 1'b1;
					res_cnt_q    <= cnt_q - 1'b1;
					items_q[l_q] <= cnt_q - 1'b1;
					if (cnt_q == cnt_t'(1)) begin
						cur_v_q[l_q] <= 1'b0;
					end else begin
						tail_q[l_q]  <= prev_rd;
						cur_q[l_q]   <= prev_rd;
						cur_v_q[l_q] <= 1'b1;
					end
					st_q <= S_GIVE;
				end

				S_GIVE: begin
					fntop_q <= n_q;
					fntot_q <= fntot_q + 1'b1;
					st_q    <= S_EMIT;
				end

				S_FREE_RD: begin
					st_q <= S_FREE;
				end

				S_FREE: begin
					res_status_q <= ST_OK;
					res_item_q   <= item_rd;
					res_iv_q     <= 1'b1;
					res_cnt_q    <= '0;
					res_nid_q    <= '0;
					res_last_q   <= (it_q == cnt_t'(1));
					fntop_q      <= n_q;
					fntot_q      <= fntot_q + 1'b1;
					n_q          <= next_rd;
					it_q         <= it_q - 1'b1;
					if (it_q == cnt_t'(1)) begin
						items_q[l_q] <= '0;
						cur_v_q[l_q] <= 1'b0;
						inuse_q[l_q] <= 1'b0;
						flink_q[l_q] <= fltop_q;
						fltop_q      <= l_q;
						fltot_q      <= fltot_q + 1'b1;
					end
					st_q <= S_EMIT;
				end

				S_SR: begin
					// one node per cycle; next node address is fed from the read data
					if (match_w) begin
						res_item_q   <= item_rd;
						res_iv_q     <= 1'b1;
						cur_q[l_q]   <= n_q;
						cur_v_q[l_q] <= 1'b1;
						st_q         <= S_EMIT;
					end else if (n_q == tl_q || it_q == cnt_t'(NUM_NODES - 1)) begin
						cur_v_q[l_q] <= 1'b0;
						bey_q[l_q]   <= 1'b1;
						st_q         <= S_EMIT;
					end else begin
						n_q  <= next_rd;
						it_q <= it_q + 1'b1;
					end
				end

				S_EMIT: begin
					if (emit_w) begin
						st_q <= res_last_q ? S_IDLE : S_FREE_RD;
					end
				end

				default: st_q <= S_IDLE;
			endcase
		end
	end

endmodule

// ----- sv/clpu_node_mem.sv -----
// ----------------------------------------------------------------------------
// clpu_node_mem
// Node pool storage: item, next and prev arrays, one shared read address,
// registered read data, an independent write port per array.
// ----------------------------------------------------------------------------
module clpu_node_mem
	import clpu_pkg::*;
(
	input  logic     clk,
	input  node_t    rd_addr,
	input  node_wr_t wr,
	output item_t    item_rd,
	output node_t    next_rd,
	output node_t    prev_rd
);

	item_t node_item [NUM_NODES];
	node_t node_next [NUM_NODES];
	node_t node_prev [NUM_NODES];

	always_ff @(posedge clk) begin
		if (wr.item_we) begin
			node_item[wr.item_wa] <= wr.item_wd;
		end
		if (wr.next_we) begin
			node_next[wr.next_wa] <= wr.next_wd;
		end
		if (wr.prev_we) begin
			node_prev[wr.prev_wa] <= wr.prev_wd;
		end
		item_rd <= node_item[rd_addr];
		next_rd <= node_next[rd_addr];
		prev_rd <= node_prev[rd_addr];
	end

endmodule
